// ===== hdl/asr_pkg.sv =====
// Package with shared types, constants and helpers of the agent schedule scorer.
package asr_pkg;

    localparam int unsigned AGING_DIVISOR_DEF  = 5;
    localparam int unsigned VRUNTIME_SHIFT_DEF = 2;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_PRIORITY = 3'd0,
        CFG_AGING_CAP        = 3'd1,
        CFG_BUDGET_PENALTY   = 3'd2,
        CFG_DEADLINE_WINDOW  = 3'd3,
        CFG_DEADLINE_BONUS   = 3'd4
    } cfg_idx_t;

    localparam logic [3:0] DEFAULT_PRIORITY_RST = 4'd5;
    localparam logic [5:0] AGING_CAP_RST        = 6'd20;
    localparam logic [4:0] BUDGET_PENALTY_RST   = 5'd5;
    localparam logic [7:0] DEADLINE_WINDOW_RST  = 8'd5;
    localparam logic [5:0] DEADLINE_BONUS_RST   = 6'd15;

    localparam int AGE_W     = 6;
    localparam int AGE_LIMIT = 2 ** AGE_W;
    localparam int SCORE_W   = 30;
    localparam int SUM_W     = 32;
    localparam int PART_W    = 11;
    localparam int POS_W     = 10;

    localparam logic signed [SUM_W-1:0] SCORE_LOW = -32'sd268435461;

    localparam logic [4:0] EVT_MESSAGE_PTS   = 5'd30;
    localparam logic [4:0] EVT_PARENT_PTS    = 5'd25;
    localparam logic [4:0] EVT_FILE_PTS      = 5'd20;
    localparam logic [4:0] EVT_HEARTBEAT_PTS = 5'd10;
    localparam logic [4:0] EVT_NONE_PTS      = 5'd0;

    typedef struct packed {
        logic [3:0] default_priority;
        logic [5:0] aging_cap;
        logic [4:0] budget_penalty;
        logic [7:0] deadline_window;
        logic [5:0] deadline_bonus;
    } cfg_t;

    typedef struct packed {
        logic        runnable;
        logic        agent;
        logic [31:0] since_fix;
        logic [31:0] diff;
        logic [3:0]  prio;
        logic [4:0]  evt;
        logic [3:0]  boost;
        logic [29:0] vrt_sh;
        logic        exhausted;
        logic        dl_near;
    } s1_t;

    typedef struct packed {
        logic                     runnable;
        logic                     agent;
        logic [31:0]              since_fix;
        logic                     big;
        logic [29:0]              vrt_sh;
        logic                     penalized;
        logic signed [PART_W-1:0] part;
    } s2_t;

    // The lowest set flag decides the event weight.
    function automatic logic [4:0] event_points(input logic [3:0] flags);
        logic [4:0] pts;
        priority if (flags[0]) pts = EVT_MESSAGE_PTS;
        else if (flags[1])     pts = EVT_PARENT_PTS;
        else if (flags[2])     pts = EVT_FILE_PTS;
        else if (flags[3])     pts = EVT_HEARTBEAT_PTS;
        else                   pts = EVT_NONE_PTS;
        return pts;
    endfunction

endpackage

// ===== hdl/asr_if.sv =====
// Valid/ready channel interfaces for task items and score items.
interface asr_in_if;
    logic               valid;
    logic               ready;
    logic               is_runnable;
    logic               is_agent;
    logic [31:0]        now_tick;
    logic [31:0]        since_tick;
    logic [3:0]         base_priority;
    logic [3:0]         sched_priority;
    logic [3:0]         event_flags;
    logic [3:0]         boost_level;
    logic [29:0]        virtual_runtime;
    logic signed [15:0] budget_left;
    logic [31:0]        wait_deadline_tick;

    modport source (
        output valid, is_runnable, is_agent, now_tick, since_tick, base_priority,
               sched_priority, event_flags, boost_level, virtual_runtime,
               budget_left, wait_deadline_tick,
        input  ready
    );
    modport sink (
        input  valid, is_runnable, is_agent, now_tick, since_tick, base_priority,
               sched_priority, event_flags, boost_level, virtual_runtime,
               budget_left, wait_deadline_tick,
        output ready
    );
endinterface

interface asr_out_if;
    logic               valid;
    logic               ready;
    logic               eligible;
    logic signed [29:0] score;
    logic [31:0]        new_since_tick;
    logic               budget_penalized;

    modport source (
        output valid, eligible, score, new_since_tick, budget_penalized,
        input  ready
    );
    modport sink (
        input  valid, eligible, score, new_since_tick, budget_penalized,
        output ready
    );
endinterface

// ===== hdl/asr_cfg.sv =====
// Configuration register file of the agent schedule scorer.
module asr_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asr_pkg::CFG_W-1:0]       cfg_data,
    output asr_pkg::cfg_t                   cfg
);
    import asr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_priority <= DEFAULT_PRIORITY_RST;
            cfg_reg.aging_cap        <= AGING_CAP_RST;
            cfg_reg.budget_penalty   <= BUDGET_PENALTY_RST;
            cfg_reg.deadline_window  <= DEADLINE_WINDOW_RST;
            cfg_reg.deadline_bonus   <= DEADLINE_BONUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_PRIORITY: cfg_reg.default_priority <= cfg_data[3:0];
                CFG_AGING_CAP:        cfg_reg.aging_cap        <= cfg_data[5:0];
                CFG_BUDGET_PENALTY:   cfg_reg.budget_penalty   <= cfg_data[4:0];
                CFG_DEADLINE_WINDOW:  cfg_reg.deadline_window  <= cfg_data[7:0];
                CFG_DEADLINE_BONUS:   cfg_reg.deadline_bonus   <= cfg_data[5:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hdl/asr_stage1.sv =====
// First pipeline stage: stamp correction, tick difference, deadline test and field decode.
module asr_stage1 #(
    parameter int unsigned VRUNTIME_SHIFT = asr_pkg::VRUNTIME_SHIFT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    asr_in_if.sink         task_in,
    input  asr_pkg::cfg_t  cfg,
    input  logic           adv_next,
    output logic           valid,
    output asr_pkg::s1_t   data
);
    import asr_pkg::*;

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic        take;
    logic [31:0] since_fix;
    logic [32:0] dl_limit;

    assign take         = !valid_reg || adv_next;
    assign task_in.ready = take;

    always_comb
    begin
        if (task_in.since_tick != 32'd0)
            since_fix = task_in.since_tick;
        else if (task_in.now_tick != 32'd0)
            since_fix = task_in.now_tick;
        else
            since_fix = 32'd1;

        dl_limit = {1'b0, task_in.now_tick} + {25'd0, cfg.deadline_window};

        data_next.runnable  = task_in.is_runnable;
        data_next.agent     = task_in.is_agent;
        data_next.since_fix = task_in.is_runnable ? since_fix : task_in.since_tick;
        data_next.diff      = (task_in.now_tick > since_fix) ?
                              (task_in.now_tick - since_fix) : 32'd0;
        data_next.prio      = (task_in.sched_priority > task_in.base_priority) ?
                              task_in.sched_priority : task_in.base_priority;
        data_next.evt       = event_points(task_in.event_flags);
        data_next.boost     = task_in.boost_level;
        data_next.vrt_sh    = task_in.virtual_runtime >> VRUNTIME_SHIFT;
        data_next.exhausted = (task_in.budget_left <= 16'sd0);
        data_next.dl_near   = (task_in.wait_deadline_tick != 32'd0) &&
                              ({1'b0, task_in.wait_deadline_tick} <= dl_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= task_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && task_in.valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

// ===== hdl/asr_stage2.sv =====
// Second pipeline stage: reciprocal multiply for the aging quotient and the narrow score terms.
module asr_stage2 #(
    parameter int unsigned AGING_DIVISOR = asr_pkg::AGING_DIVISOR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  asr_pkg::s1_t         in_data,
    input  asr_pkg::cfg_t        cfg,
    input  logic                 adv_next,
    output logic                 take,
    output logic                 valid,
    output asr_pkg::s2_t         data,
    output logic [asr_pkg::AGE_W + 2*$clog2(asr_pkg::AGE_LIMIT*AGING_DIVISOR)
                  + $clog2(AGING_DIVISOR):0] prod
);
    import asr_pkg::*;

    // Any difference of at least AgeSpan gives a quotient above every cap value.
    localparam int AgeSpan = AGE_LIMIT * AGING_DIVISOR;
    localparam int NumW    = $clog2(AgeSpan);
    localparam int ShW     = $clog2(AGING_DIVISOR);
    localparam int Sh      = NumW + ShW;
    localparam int Mult    = (2 ** Sh + AGING_DIVISOR - 1) / AGING_DIVISOR;
    localparam int ProdW   = AGE_W + 2 * NumW + ShW + 1;

    logic             valid_reg;
    s2_t              data_reg;
    s2_t              data_next;
    logic [ProdW-1:0] prod_reg;
    logic [ProdW-1:0] prod_next;
    logic [POS_W-1:0] pos;
    logic [4:0]       neg;

    assign take = !valid_reg || adv_next;

    always_comb
    begin
        pos = POS_W'(in_data.prio) * POS_W'(10);
        if (in_data.agent)
        begin
            pos = pos + POS_W'(in_data.evt) + POS_W'(in_data.boost) * POS_W'(10);
            if (in_data.dl_near)
                pos = pos + POS_W'(cfg.deadline_bonus);
        end
        if (!in_data.agent)
            pos = POS_W'(cfg.default_priority) * POS_W'(10);
        neg = (in_data.agent && in_data.exhausted) ? cfg.budget_penalty : 5'd0;

        data_next.runnable  = in_data.runnable;
        data_next.agent     = in_data.agent;
        data_next.since_fix = in_data.since_fix;
        data_next.big       = (in_data.diff >= 32'(AgeSpan));
        data_next.vrt_sh    = in_data.agent ? in_data.vrt_sh : 30'd0;
        data_next.penalized = in_data.runnable && in_data.agent && in_data.exhausted;
        data_next.part      = signed'({1'b0, pos}) - signed'(PART_W'(neg));

        prod_next = ProdW'(in_data.diff[NumW-1:0]) * ProdW'(Mult);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            data_reg <= data_next;
            prod_reg <= prod_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign prod  = prod_reg;
endmodule

// ===== hdl/asr_stage3.sv =====
// Third pipeline stage: aging cap, final sum, low saturation and the output register.
module asr_stage3 #(
    parameter int unsigned AGING_DIVISOR = asr_pkg::AGING_DIVISOR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  asr_pkg::s2_t         in_data,
    input  logic [asr_pkg::AGE_W + 2*$clog2(asr_pkg::AGE_LIMIT*AGING_DIVISOR)
                  + $clog2(AGING_DIVISOR):0] prod,
    input  asr_pkg::cfg_t        cfg,
    output logic                 take,
    asr_out_if.source            score_out
);
    import asr_pkg::*;

    localparam int NumW = $clog2(AGE_LIMIT * AGING_DIVISOR);
    localparam int Sh   = NumW + $clog2(AGING_DIVISOR);

    logic                      valid_reg;
    logic                      eligible_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [31:0]               since_reg;
    logic                      pen_reg;
    logic [AGE_W-1:0]          quot;
    logic [AGE_W-1:0]          aging;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SCORE_W-1:0] score_next;

    assign take = !valid_reg || score_out.ready;

    always_comb
    begin
        quot = prod[Sh +: AGE_W];
        if (in_data.big || (quot > cfg.aging_cap))
            aging = cfg.aging_cap;
        else
            aging = quot;

        sum = SUM_W'(in_data.part) + signed'(SUM_W'(aging))
              - signed'(SUM_W'(in_data.vrt_sh));
        if (!in_data.runnable)
            score_next = -30'sd1;
        else if (sum < SCORE_LOW)
            score_next = SCORE_LOW[SCORE_W-1:0];
        else
            score_next = sum[SCORE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            eligible_reg <= in_data.runnable;
            score_reg    <= score_next;
            since_reg    <= in_data.since_fix;
            pen_reg      <= in_data.penalized;
        end
    end

    assign score_out.valid            = valid_reg;
    assign score_out.eligible         = eligible_reg;
    assign score_out.score            = score_reg;
    assign score_out.new_since_tick   = since_reg;
    assign score_out.budget_penalized = pen_reg;
endmodule

// ===== hdl/agent_schedule_scorer.sv =====
// Top level of the agent schedule scorer: configuration registers and a three-stage pipeline.
// A task item passes the stage-one, stage-two and stage-three registers in order; the
// stage-three register holds the result item until score_out takes it.
// Throughput is one item per cycle; the three stages each hold one item and advance
// under back-pressure, so a stalled output holds its item while upstream stages fill.
// Reset clears all pipeline valid bits and loads the configuration register defaults.
module agent_schedule_scorer #(
    parameter int unsigned AGING_DIVISOR  = asr_pkg::AGING_DIVISOR_DEF,
    parameter int unsigned VRUNTIME_SHIFT = asr_pkg::VRUNTIME_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    asr_in_if.sink                        task_in,
    asr_out_if.source                     score_out,
    input  logic                          cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [asr_pkg::CFG_W-1:0]     cfg_data
);
    import asr_pkg::*;

    localparam int ProdW = AGE_W + 2 * $clog2(AGE_LIMIT * AGING_DIVISOR)
                           + $clog2(AGING_DIVISOR) + 1;

    cfg_t             cfg;
    logic             s1_valid;
    s1_t              s1_data;
    logic             s2_take;
    logic             s2_valid;
    s2_t              s2_data;
    logic [ProdW-1:0] s2_prod;
    logic             s3_take;

    asr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asr_stage1 #(
        .VRUNTIME_SHIFT (VRUNTIME_SHIFT)
    ) u_stage1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .task_in  (task_in),
        .cfg      (cfg),
        .adv_next (s2_take),
        .valid    (s1_valid),
        .data     (s1_data)
    );

    asr_stage2 #(
        .AGING_DIVISOR (AGING_DIVISOR)
    ) u_stage2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .in_data  (s1_data),
        .cfg      (cfg),
        .adv_next (s3_take),
        .take     (s2_take),
        .valid    (s2_valid),
        .data     (s2_data),
        .prod     (s2_prod)
    );

    asr_stage3 #(
        .AGING_DIVISOR (AGING_DIVISOR)
    ) u_stage3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .prod      (s2_prod),
        .cfg       (cfg),
        .take      (s3_take),
        .score_out (score_out)
    );
endmodule
